>>> rtl/wireworld_grid_step_core_defines.svh
// Assertion macros for the Wireworld grid stepper.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef WIREWORLD_GRID_STEP_CORE_DEFINES_SVH
`define WIREWORLD_GRID_STEP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define WWG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define WWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wwg_pkg.sv
// Shared types and constants for the Wireworld grid stepper.
// No dependencies; used by wwg_rule and the top level.
package wwg_pkg;

  localparam int CfgW = 7;
  localparam logic [CfgW-1:0] SizeReset = 7'd64;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_HEAD  = 2'd1,
    CELL_TAIL  = 2'd2,
    CELL_COND  = 2'd3
  } cell_e;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] cell_value;
  } in_t;

  typedef struct packed {
    logic [1:0] read_value;
    logic       coord_error;
  } out_t;

  // Size in use: zero reads as one, anything above the maximum as the maximum.
  function automatic logic [CfgW-1:0] eff_size(logic [CfgW-1:0] size_v, int max_v);
    logic [CfgW-1:0] res;
    if (size_v == '0) begin
      res = CfgW'(1);
    end else if (int'(size_v) > max_v) begin
      res = CfgW'(max_v);
    end else begin
      res = size_v;
    end
    return res;
  endfunction

endpackage

>>> rtl/wwg_mem.sv
// Row memory of the Wireworld grid: one write and one read port,
// read data registered. No package dependencies.
module wwg_mem #(
  parameter int AddrW = 7,
  parameter int DataW = 128
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wwg_rule.sv
// One row of Wireworld update lanes, one lane per column.
// Depends on wwg_pkg for the cell codes.
module wwg_rule #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [2*MAX_WIDTH-1:0]  top_i,
  input  logic [2*MAX_WIDTH-1:0]  mid_i,
  input  logic [2*MAX_WIDTH-1:0]  bot_i,
  input  logic [wwg_pkg::CfgW-1:0] width_i,
  output logic [2*MAX_WIDTH-1:0]  next_o
);

  // Head flags padded by one dead column on each side.
  logic [MAX_WIDTH+1:0] hd_top;
  logic [MAX_WIDTH+1:0] hd_mid;
  logic [MAX_WIDTH+1:0] hd_bot;
  logic [3:0]           cnt [MAX_WIDTH];

  always_comb begin
    hd_top = '0;
    hd_mid = '0;
    hd_bot = '0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      if (c < int'(width_i)) begin
        hd_top[c+1] = (top_i[2*c +: 2] == wwg_pkg::CELL_HEAD);
        hd_mid[c+1] = (mid_i[2*c +: 2] == wwg_pkg::CELL_HEAD);
        hd_bot[c+1] = (bot_i[2*c +: 2] == wwg_pkg::CELL_HEAD);
      end
    end
  end

  always_comb begin
    next_o = '0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      cnt[c] = 4'(hd_top[c]) + 4'(hd_top[c+1]) + 4'(hd_top[c+2])
             + 4'(hd_mid[c]) + 4'(hd_mid[c+2])
             + 4'(hd_bot[c]) + 4'(hd_bot[c+1]) + 4'(hd_bot[c+2]);
      if (c < int'(width_i)) begin
        case (mid_i[2*c +: 2])
          wwg_pkg::CELL_HEAD: next_o[2*c +: 2] = wwg_pkg::CELL_TAIL;
          wwg_pkg::CELL_TAIL: next_o[2*c +: 2] = wwg_pkg::CELL_COND;
          wwg_pkg::CELL_COND: begin
            next_o[2*c +: 2] = (cnt[c] == 4'd1 || cnt[c] == 4'd2) ?
                               wwg_pkg::CELL_HEAD : wwg_pkg::CELL_COND;
          end
          default: next_o[2*c +: 2] = wwg_pkg::CELL_EMPTY;
        endcase
      end
    end
  end

endmodule

>>> rtl/wireworld_grid_step_core.sv
// Top level of the Wireworld grid stepper: control sequencer around the row memory.
// Depends on wwg_pkg, wwg_mem, wwg_rule and wireworld_grid_step_core_defines.svh.
//
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------
// in       | input     | in_valid_i / in_ready_o | in_data_i  (wwg_pkg::in_t)
// out      | output    | out_valid_o/out_ready_i | out_data_o (wwg_pkg::out_t)
// cfg      | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i (7 bits)
//
// Sequence: a write or read does a row read, then the write-back or pick, then the result
// load; an out-of-grid access or the unused action goes straight to the result load; a
// step does height + 1 row reads, one a cycle, one lane per column, then the result load;
// the next transaction is taken in the cycle after the result load.
// Reset and every configuration write clear bank 0, taking nothing meanwhile.
// A stalled result holds the output register; only the result load waits for it.
`include "wireworld_grid_step_core_defines.svh"

module wireworld_grid_step_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  wwg_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output wwg_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [wwg_pkg::CfgW-1:0] cfg_data_i
);

  // One memory word holds a whole row; address is {bank, row}.
  localparam int RowW    = $clog2(MAX_HEIGHT);
  localparam int AddrW   = RowW + 1;
  localparam int RowBits = 2 * MAX_WIDTH;
  localparam int CntW    = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ACCESS = 5'b00100,
    ST_STEP   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic                     bank_q, bank_d;
  logic [wwg_pkg::CfgW-1:0] width_q, width_d;
  logic [wwg_pkg::CfgW-1:0] height_q, height_d;
  logic [RowW-1:0]          clr_q, clr_d;
  logic [CntW-1:0]          iss_q, iss_d;
  logic [CntW-1:0]          arr_q, arr_d;
  logic                     arr_vld_q, arr_vld_d;
  logic                     res_valid_q, res_valid_d;
  wwg_pkg::in_t             req_q, req_d;
  wwg_pkg::out_t            pend_q, pend_d;
  wwg_pkg::out_t            res_q, res_d;
  logic [RowBits-1:0]       top_q, top_d;
  logic [RowBits-1:0]       mid_q, mid_d;

  logic [wwg_pkg::CfgW-1:0] w_eff;
  logic [wwg_pkg::CfgW-1:0] h_eff;
  logic                     in_acc;
  logic                     coord_bad;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [RowBits-1:0]       mem_wdata;
  logic [AddrW-1:0]         mem_raddr;
  logic [RowBits-1:0]       mem_rdata;
  logic [RowBits-1:0]       below;
  logic [RowBits-1:0]       next_row;
  logic [RowBits-1:0]       patched;
  logic [1:0]               cell_rd;
  logic                     step_we;
  logic                     step_last;

  assign w_eff = wwg_pkg::eff_size(width_q, MAX_WIDTH);
  assign h_eff = wwg_pkg::eff_size(height_q, MAX_HEIGHT);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  assign coord_bad = ({1'b0, in_data_i.col} >= w_eff) || ({1'b0, in_data_i.row} >= h_eff);

  // Rows past the bottom of the grid in use read as empty.
  assign below = (int'(arr_q) < int'(h_eff)) ? mem_rdata : '0;

  // Step write strobe and the cycle that retires the last row of a step.
  assign step_we   = (state_q == ST_STEP) && mem_we;
  assign step_last = (state_q == ST_STEP) && arr_vld_q && (int'(arr_q) == int'(h_eff));

  // Patch one cell into the fetched row, or pick it out for a read.
  always_comb begin
    patched = mem_rdata;
    cell_rd = '0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      if (int'(req_q.col) == c) begin
        patched[2*c +: 2] = req_q.cell_value;
        cell_rd           = mem_rdata[2*c +: 2];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    width_d     = width_q;
    height_d    = height_q;
    clr_d       = clr_q;
    iss_d       = iss_q;
    arr_d       = arr_q;
    arr_vld_d   = arr_vld_q;
    req_d       = req_q;
    pend_d      = pend_q;
    res_d       = res_q;
    top_d       = top_q;
    mid_d       = mid_q;
    res_valid_d = res_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = {bank_q, RowW'(in_data_i.row)};

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep bank 0 to empty, one row a cycle.
        mem_we    = 1'b1;
        mem_waddr = {1'b0, clr_q};
        clr_d     = clr_q + 1'b1;
        if (clr_q == RowW'(MAX_HEIGHT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_d     = in_data_i;
          pend_d    = '0;
          iss_d     = '0;
          arr_vld_d = 1'b0;
          top_d     = '0;
          mid_d     = '0;
          case (in_data_i.action) inside
            wwg_pkg::ACT_WRITE, wwg_pkg::ACT_READ: begin
              if (coord_bad) begin
                pend_d.coord_error = 1'b1;
                state_d            = ST_FINISH;
              end else begin
                state_d = ST_ACCESS;
              end
            end
            wwg_pkg::ACT_STEP: state_d = ST_STEP;
            default:           state_d = ST_FINISH;
          endcase
        end
      end
      ST_ACCESS: begin
        // Row fetched at acceptance is here: write it back or pick the cell.
        if (req_q.action == wwg_pkg::ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = {bank_q, RowW'(req_q.row)};
          mem_wdata = patched;
        end else begin
          pend_d.read_value = cell_rd;
        end
        state_d = ST_FINISH;
      end
      ST_STEP: begin
        // Issue rows 0..height of the current bank; the last one reads as empty.
        mem_raddr = {bank_q, RowW'(iss_q)};
        arr_vld_d = (int'(iss_q) <= int'(h_eff));
        arr_d     = iss_q;
        if (int'(iss_q) <= int'(h_eff)) begin
          iss_d = iss_q + 1'b1;
        end
        // Row arrives: update the row above it into the other bank and slide the window.
        if (arr_vld_q) begin
          top_d = mid_q;
          mid_d = below;
          if (arr_q != '0) begin
            mem_we    = 1'b1;
            mem_waddr = {~bank_q, RowW'(arr_q - CntW'(1))};
            mem_wdata = next_row;
          end
          if (int'(arr_q) == int'(h_eff)) begin
            bank_d  = ~bank_q;
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free, then load the result.
        if (!res_valid_q || out_ready_i) begin
          res_valid_d = 1'b1;
          res_d       = pend_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    // A size change starts a fresh empty grid.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wwg_pkg::REG_GRID_WIDTH:  width_d  = cfg_data_i;
        wwg_pkg::REG_GRID_HEIGHT: height_d = cfg_data_i;
        default:                  width_d  = width_q;
      endcase
      state_d = ST_CLEAR;
      clr_d   = '0;
      bank_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      bank_q      <= 1'b0;
      width_q     <= wwg_pkg::SizeReset;
      height_q    <= wwg_pkg::SizeReset;
      clr_q       <= '0;
      iss_q       <= '0;
      arr_vld_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      width_q     <= width_d;
      height_q    <= height_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      arr_vld_q   <= arr_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q  <= arr_d;
    req_q  <= req_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    top_q  <= top_d;
    mid_q  <= mid_d;
  end

  wwg_mem #(
    .AddrW(AddrW),
    .DataW(RowBits)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  wwg_rule #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_rule (
    .top_i  (top_q),
    .mid_i  (mid_q),
    .bot_i  (below),
    .width_i(w_eff),
    .next_o (next_row)
  );

  // A step never overwrites the generation it is reading.
  `WWG_ASSERT_SAME(a_step_other_bank, step_we, mem_waddr[AddrW-1] != bank_q, "step bank clash")
  // The last row of a step makes the new generation current.
  `WWG_ASSERT_NEXT(a_step_flip, step_last, bank_q != $past(bank_q), "bank not swapped")
  // A size change blocks new transactions while the grid is cleared.
  `WWG_ASSERT_NEXT(a_cfg_clears, cfg_we_i, !in_ready_o, "transaction taken during clearing pass")

endmodule

>>> bench/wireworld_grid_step_core_tb.sv
// Self-checking bench for wireworld_grid_step_core: cell writes, reads and whole-grid steps.
// Depends on wwg_pkg and the RTL top level; a scoreboard class tracks both cell banks.
module wireworld_grid_step_core_tb;

  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  // Action code with no meaning to the block: must pass through as a no-op.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HoldCycles = 250;
  localparam int SettleCycles = 100;
  localparam int Phases = 6;
  localparam int PhaseItems = 20;

  // Track the grid, predict one result per accepted transaction and check
  // the block's results in order.
  class grid_tracker;
    wwg_pkg::cell_e  cells [2][MaxRows][MaxCols];
    bit              cur_bank;
    logic [6:0]      width_reg;
    logic [6:0]      height_reg;
    wwg_pkg::out_t   expected_replies [$];
    int unsigned mismatches, commands_seen, reads_seen, steps_seen, errors_seen;
    int unsigned settings_seen, ignited;

    function new();
      clear_cells();
      width_reg  = wwg_pkg::SizeReset;
      height_reg = wwg_pkg::SizeReset;
    endfunction

    function void clear_cells();
      foreach (cells[b, r, c]) cells[b][r][c] = wwg_pkg::CELL_EMPTY;
      cur_bank = 1'b0;
    endfunction

    function int in_use(logic [6:0] size_v, int max_v);
      if (size_v == 0) return 1;
      if (size_v > max_v) return max_v;
      return size_v;
    endfunction

    function int cols();
      return in_use(width_reg, MaxCols);
    endfunction

    function int rows();
      return in_use(height_reg, MaxRows);
    endfunction

    function int unsigned outstanding();
      return expected_replies.size();
    endfunction

    // A size write empties the whole grid and makes bank 0 current.
    function void apply_setting(wwg_pkg::reg_idx_e idx, logic [6:0] val);
      if (idx == wwg_pkg::REG_GRID_WIDTH) width_reg = val;
      else height_reg = val;
      clear_cells();
      settings_seen++;
    endfunction

    function void take_command(wwg_pkg::in_t cmd);
      wwg_pkg::out_t  want;
      int             w, h, r, c, dr, dc, nr, nc, heads;
      bit             nxt;
      wwg_pkg::cell_e fresh;
      want = '0;
      w = cols();
      h = rows();
      case (cmd.action) inside
        wwg_pkg::ACT_WRITE, wwg_pkg::ACT_READ: begin
          if (cmd.col >= w || cmd.row >= h) begin
            want.coord_error = 1'b1;
            errors_seen++;
          end else if (cmd.action == wwg_pkg::ACT_WRITE) begin
            cells[cur_bank][cmd.row][cmd.col] = wwg_pkg::cell_e'(cmd.cell_value);
          end else begin
            want.read_value = cells[cur_bank][cmd.row][cmd.col];
            reads_seen++;
          end
        end
        wwg_pkg::ACT_STEP: begin
          nxt = ~cur_bank;
          for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
              case (cells[cur_bank][r][c])
                wwg_pkg::CELL_EMPTY: fresh = wwg_pkg::CELL_EMPTY;
                wwg_pkg::CELL_HEAD:  fresh = wwg_pkg::CELL_TAIL;
                wwg_pkg::CELL_TAIL:  fresh = wwg_pkg::CELL_COND;
                default: begin
                  // Count heads among the eight neighbours; no wrap at the edges.
                  heads = 0;
                  for (dr = -1; dr <= 1; dr++) begin
                    for (dc = -1; dc <= 1; dc++) begin
                      nr = r + dr;
                      nc = c + dc;
                      if ((dr != 0 || dc != 0) && nr >= 0 && nr < h && nc >= 0 && nc < w &&
                          cells[cur_bank][nr][nc] == wwg_pkg::CELL_HEAD) heads++;
                    end
                  end
                  fresh = (heads == 1 || heads == 2) ? wwg_pkg::CELL_HEAD : wwg_pkg::CELL_COND;
                  if (fresh == wwg_pkg::CELL_HEAD) ignited++;
                end
              endcase
              cells[nxt][r][c] = fresh;
            end
          end
          cur_bank = nxt;
          steps_seen++;
        end
        default: ;
      endcase
      commands_seen++;
      expected_replies.push_back(want);
    endfunction

    function void check_reply(wwg_pkg::out_t got);
      wwg_pkg::out_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: result with nothing expected: read_value %0d coord_error %0d",
                 $time, got.read_value, got.coord_error);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d, got %0d",
                 $time, want.read_value, got.read_value);
        mismatches++;
      end
      if (got.coord_error !== want.coord_error) begin
        $display("%0t: coord_error expected %0d, got %0d",
                 $time, want.coord_error, got.coord_error);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  wwg_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  wwg_pkg::out_t out_data_o;
  logic          cfg_we_i    = 1'b0;
  logic          cfg_idx_i   = 1'b0;
  logic [6:0]    cfg_data_i  = '0;

  grid_tracker tracker = new();

  // Stimulus-to-receiver flags: request one long hold-off, and drop all idling.
  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  // Origin of the small window that most random accesses hit, so the cells
  // stay dense enough for wires to fire.
  int unsigned win_col = 0;
  int unsigned win_row = 0;

  // Grid shapes, one per random phase: zero and 127 test the clamping.
  logic [6:0] shape_w [Phases] = '{7'd5, 7'd3, 7'd127, 7'd1, 7'd7, 7'd64};
  logic [6:0] shape_h [Phases] = '{7'd5, 7'd9, 7'd0,   7'd1, 7'd127, 7'd64};

  wireworld_grid_step_core #(
    .MAX_WIDTH (MaxCols),
    .MAX_HEIGHT(MaxRows)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Observe both channels at the edge: a transaction completes where valid and
  // ready are both high. Check the result first, then log the new command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.check_reply(out_data_o);
      if (in_valid_i && in_ready_o) tracker.take_command(in_data_i);
    end
  end

  function automatic wwg_pkg::in_t pack_cmd(logic [1:0] act, int unsigned c, int unsigned r,
                                            logic [1:0] val);
    wwg_pkg::in_t cmd;
    cmd.action     = act;
    cmd.col        = c[5:0];
    cmd.row        = r[5:0];
    cmd.cell_value = val;
    return cmd;
  endfunction

  function automatic int unsigned window(int unsigned n);
    return (n < 6) ? n : 6;
  endfunction

  // Mostly well-formed work inside the window (writes weighted towards
  // conductor, reads, steps), plus out-of-grid accesses, the unused action
  // and accesses anywhere on the grid.
  function automatic wwg_pkg::in_t random_command();
    int unsigned w, h, c, r, pick;
    logic [1:0]  act, val;
    w    = tracker.cols();
    h    = tracker.rows();
    c    = win_col + $urandom_range(0, window(w) - 1);
    r    = win_row + $urandom_range(0, window(h) - 1);
    val  = $urandom_range(0, 1) ? wwg_pkg::CELL_COND : 2'($urandom_range(0, 3));
    act  = $urandom_range(0, 1) ? wwg_pkg::ACT_WRITE : wwg_pkg::ACT_READ;
    pick = $urandom_range(0, 99);
    if (pick < 40) return pack_cmd(wwg_pkg::ACT_WRITE, c, r, val);
    if (pick < 68) return pack_cmd(wwg_pkg::ACT_READ, c, r, 2'($urandom()));
    if (pick < 84) begin
      return pack_cmd(wwg_pkg::ACT_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                      2'($urandom()));
    end
    if (pick < 96) begin
      if (w < MaxCols && (h == MaxRows || $urandom_range(0, 1))) begin
        c = $urandom_range(w, MaxCols - 1);
        r = $urandom_range(0, MaxRows - 1);
      end else if (h < MaxRows) begin
        r = $urandom_range(h, MaxRows - 1);
        c = $urandom_range(0, MaxCols - 1);
      end
      return pack_cmd(act, c, r, 2'($urandom()));
    end
    if (pick < 98) begin
      return pack_cmd(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom()));
    end
    return pack_cmd(act, $urandom_range(0, w - 1), $urandom_range(0, h - 1), 2'($urandom()));
  endfunction

  // Offer one transaction and hold it until accepted; then sometimes idle the
  // sender for a burst. Valid stays high into the next call otherwise.
  task automatic send(input wwg_pkg::in_t cmd);
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every expected result; optionally also wait for
  // the block to take input again, which covers a clearing pass.
  task automatic drain(input bit need_ready);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0 || (need_ready && !in_ready_o));
  endtask

  // Write one size register while the block is idle.
  task automatic set_size(input wwg_pkg::reg_idx_e idx, input logic [6:0] val);
    drain(1'b1);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    tracker.apply_setting(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random ready bursts, one long hold-off on request, and a
  // steady ready once the stimulus goes calm.
  initial begin : receiver
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (span = 0; span < HoldCycles; span++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int phase, n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the 64 x 64 reset grid. Corner conductor with two
    // heads beside it fires; a conductor with three heads stays put.
    send(pack_cmd(wwg_pkg::ACT_READ,  0,  0,  wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 63, 63, wwg_pkg::CELL_COND));
    send(pack_cmd(wwg_pkg::ACT_READ,  63, 63, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 62, 63, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 63, 62, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 0,  0,  wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 1,  0,  wwg_pkg::CELL_COND));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 1,  1,  wwg_pkg::CELL_TAIL));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 10, 10, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 11, 10, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 12, 10, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 11, 11, wwg_pkg::CELL_COND));
    send(pack_cmd(wwg_pkg::ACT_STEP,  63, 0,  wwg_pkg::CELL_COND));
    send(pack_cmd(wwg_pkg::ACT_READ,  63, 63, wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_READ,  11, 11, wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_READ,  1,  0,  wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_READ,  0,  0,  wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_READ,  1,  1,  wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_STEP,  0,  63, wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_READ,  1,  0,  wwg_pkg::CELL_EMPTY));
    send(pack_cmd(ACT_UNUSED, 63, 63, wwg_pkg::CELL_COND));

    // Width zero reads as one column, height 127 as the full 64 rows.
    set_size(wwg_pkg::REG_GRID_WIDTH, 7'd0);
    set_size(wwg_pkg::REG_GRID_HEIGHT, 7'd127);
    send(pack_cmd(wwg_pkg::ACT_WRITE, 0,  63, wwg_pkg::CELL_HEAD));
    send(pack_cmd(wwg_pkg::ACT_WRITE, 1,  0,  wwg_pkg::CELL_COND));
    send(pack_cmd(wwg_pkg::ACT_READ,  63, 63, wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_STEP,  0,  0,  wwg_pkg::CELL_EMPTY));
    send(pack_cmd(wwg_pkg::ACT_READ,  0,  63, wwg_pkg::CELL_EMPTY));

    // Random phases, one grid shape each.
    for (phase = 0; phase < Phases; phase++) begin
      set_size(wwg_pkg::REG_GRID_WIDTH, shape_w[phase]);
      set_size(wwg_pkg::REG_GRID_HEIGHT, shape_h[phase]);
      win_col = $urandom_range(0, tracker.cols() - window(tracker.cols()));
      win_row = $urandom_range(0, tracker.rows() - window(tracker.rows()));
      // Stall the result side long enough to back the block up into its input.
      if (phase == 1) hold_req = 1'b1;
      // Last phase runs flat out on both sides.
      if (phase == Phases - 1) calm = 1'b1;
      for (n = 0; n < PhaseItems; n++) begin
        // Pause the sender mid-phase until the block has emptied.
        if (phase == 2 && n == PhaseItems / 2) drain(1'b0);
        send(random_command());
      end
    end

    // Let the last results out, then watch a while longer for strays.
    drain(1'b0);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d transactions over %0d size writes: %0d reads, %0d generations,",
             tracker.commands_seen, tracker.settings_seen, tracker.reads_seen,
             tracker.steps_seen);
    $display("%0d out-of-grid; conductors fired by neighbouring heads: %0d",
             tracker.errors_seen, tracker.ignited);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
